FILE: hdl/png_unf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
package png_unf_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DEPTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_KIND   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STRIDE = 3'd3;

  // Register field widths
  localparam int WIDTH_W  = 13;
  localparam int DEPTH_W  = 5;
  localparam int COLOR_W  = 3;
  localparam int STRIDE_W = 4;

  // Row length arithmetic: width * channels * depth fits in 20 bits
  localparam int ROW_BITS_W = 20;
  localparam int ROW_LEN_W  = 18;

  // Left and upper-left history windows
  localparam int HIST_DEPTH = 8;
  localparam int HIST_IDX_W = 3;
  localparam logic [STRIDE_W-1:0] MAX_STRIDE = 4'd8;

  // Colour types with more than one channel
  localparam logic [COLOR_W-1:0] COLOR_RGB        = 3'd2;
  localparam logic [COLOR_W-1:0] COLOR_GRAY_ALPHA = 3'd4;
  localparam logic [COLOR_W-1:0] COLOR_RGBA       = 3'd6;

  // Row filter types
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_row;
    logic       bad_filter;
  } out_beat_t;

  // Neighbour bytes handed to the reconstruction logic
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } nbr_t;

endpackage

FILE: hdl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: row tracking, row store and output register.
//
// Takes one filtered byte per beat, one byte per cycle unless the output stalls; a byte
// passes the stage-one and output registers to its result beat. A filter-type byte
// gives no result. The rate is set by the row store: one RAM of MAX_ROW_BYTES bytes,
// read for the byte above when a byte is accepted and written with the rebuilt byte as
// it moves to the output register; left and upper-left bytes come from eight-entry
// registers. The row store is not cleared after reset; the first row of each image reads
// the row above as zeros, and the row length should not grow in the middle of an image.
// Configuration must be written by the user only while no beat is in flight (unchecked).
module png_scanline_unfilter
  import png_unf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 32768
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_beat_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic [7:0]            row_filter;
    logic                  last_of_row;
    logic                  above_zero;
    logic                  left_edge;
    logic [HIST_IDX_W-1:0] cur_idx;
    logic [HIST_IDX_W-1:0] left_idx;
  } stage_t;

  // Configuration registers
  logic [WIDTH_W-1:0]  image_width;
  logic [DEPTH_W-1:0]  sample_depth;
  logic [COLOR_W-1:0]  color_kind;
  logic [STRIDE_W-1:0] pixel_stride;

  // Row tracking
  logic [COL_W-1:0] column_index;
  logic             awaiting_type;
  logic             on_first_row;
  logic [7:0]       row_filter;

  // Pipeline
  logic             s1_valid;
  stage_t           s1;
  logic [COL_W-1:0] s1_col;
  logic [7:0]       above_q;
  logic [7:0]       left_hist [HIST_DEPTH];
  logic [7:0]       upleft_hist [HIST_DEPTH];

  logic                  in_fire;
  logic                  take_type;
  logic                  first_eff;
  logic                  data_fire;
  logic                  s2_move;
  logic                  row_wr;
  logic [WIDTH_W+1:0]    width_ch;
  logic [ROW_BITS_W-1:0] row_bits;
  logic [ROW_LEN_W-1:0]  row_bytes;
  logic [ROW_LEN_W-1:0]  row_len;
  logic [STRIDE_W-1:0]   stride;
  logic                  last_now;
  nbr_t                  nbr;
  logic [7:0]            pixel_byte;
  logic                  bad_filter;

  // Handshake
  assign s2_move  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_move;
  assign in_fire  = in_valid && in_ready;
  assign row_wr   = s1_valid && s2_move;

  // Row length in bytes and stride, from the configuration
  always_comb begin
    case (color_kind)
      COLOR_RGB:        width_ch = (WIDTH_W+2)'(image_width) + {1'b0, image_width, 1'b0};
      COLOR_GRAY_ALPHA: width_ch = {1'b0, image_width, 1'b0};
      COLOR_RGBA:       width_ch = {image_width, 2'b00};
      default:          width_ch = (WIDTH_W+2)'(image_width);
    endcase
    row_bits  = ROW_BITS_W'(width_ch) * ROW_BITS_W'(sample_depth);
    row_bytes = ROW_LEN_W'((row_bits + ROW_BITS_W'(7)) >> 3);
    if (row_bytes == '0) begin
      row_len = ROW_LEN_W'(1);
    end else if (row_bytes > ROW_LEN_W'(MAX_ROW_BYTES)) begin
      row_len = ROW_LEN_W'(MAX_ROW_BYTES);
    end else begin
      row_len = row_bytes;
    end
    if (pixel_stride == '0) begin
      stride = STRIDE_W'(1);
    end else if (pixel_stride > MAX_STRIDE) begin
      stride = MAX_STRIDE;
    end else begin
      stride = pixel_stride;
    end
  end

  // Classify the incoming beat
  always_comb begin
    take_type = awaiting_type || in_data.start_of_image;
    first_eff = on_first_row || in_data.start_of_image;
    data_fire = in_fire && !take_type;
    last_now  = (ROW_LEN_W'(column_index) + ROW_LEN_W'(1)) >= row_len;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(1);
      sample_depth <= DEPTH_W'(8);
      color_kind   <= '0;
      pixel_stride <= STRIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_SAMPLE_DEPTH: sample_depth <= cfg_wdata[DEPTH_W-1:0];
        REG_COLOR_KIND:   color_kind   <= cfg_wdata[COLOR_W-1:0];
        REG_PIXEL_STRIDE: pixel_stride <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the row position on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index  <= '0;
      awaiting_type <= 1'b1;
      on_first_row  <= 1'b1;
      row_filter    <= FILT_NONE;
    end else if (in_fire) begin
      if (take_type) begin
        row_filter    <= in_data.data_byte;
        awaiting_type <= 1'b0;
        column_index  <= '0;
        on_first_row  <= first_eff;
      end else if (last_now) begin
        column_index  <= '0;
        awaiting_type <= 1'b1;
        on_first_row  <= 1'b0;
      end else begin
        column_index  <= column_index + COL_W'(1);
      end
    end
  end

  // Stage one: hold the filtered byte while the row store is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= data_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1.data_byte   <= in_data.data_byte;
      s1.row_filter  <= row_filter;
      s1.last_of_row <= last_now;
      s1.above_zero  <= on_first_row;
      s1.left_edge   <= ROW_LEN_W'(column_index) < ROW_LEN_W'(stride);
      s1.cur_idx     <= HIST_IDX_W'(column_index);
      s1.left_idx    <= HIST_IDX_W'(column_index) - HIST_IDX_W'(stride);
      s1_col         <= column_index;
    end
  end

  png_unf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES),
    .AW    (COL_W)
  ) u_row_store (
    .clk   (clk),
    .we    (row_wr),
    .waddr (s1_col),
    .wdata (pixel_byte),
    .re    (data_fire),
    .raddr (column_index),
    .rdata (above_q)
  );

  // Gather the neighbours; zero at the left edge and on the first row
  always_comb begin
    nbr.b = s1.above_zero ? 8'd0 : above_q;
    nbr.a = s1.left_edge ? 8'd0 : left_hist[s1.left_idx];
    nbr.c = s1.left_edge ? 8'd0 : upleft_hist[s1.left_idx];
  end

  png_unf_recon u_recon (
    .filt_byte  (s1.data_byte),
    .row_filter (s1.row_filter),
    .nbr        (nbr),
    .pixel_byte (pixel_byte),
    .bad_filter (bad_filter)
  );

  // Record the rebuilt byte and its above byte for later columns
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else if (row_wr) begin
      left_hist[s1.cur_idx]   <= pixel_byte;
      upleft_hist[s1.cur_idx] <= nbr.b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_wr) begin
      out_data.pixel_byte  <= pixel_byte;
      out_data.last_of_row <= s1.last_of_row;
      out_data.bad_filter  <= bad_filter;
    end
  end

  // A filter-type beat never reaches the datapath
  a_type_no_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && take_type |=> !s1_valid)
    else $error("filter-type beat entered stage one");

  // While waiting for a filter type the column is at the row start
  a_await_col_zero: assert property (@(posedge clk) disable iff (rst)
    awaiting_type |-> column_index == '0)
    else $error("column not at row start while awaiting a filter type");

  // The final byte of a row returns the tracker to the filter type
  a_last_awaits: assert property (@(posedge clk) disable iff (rst)
    data_fire && last_now |=> awaiting_type && column_index == '0)
    else $error("row end did not return to filter type");

  // The above byte is held while stage one is stalled
  a_above_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_move |=> $stable(above_q))
    else $error("row store data changed under a stalled byte");

endmodule

FILE: hdl/png_unf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module png_unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/png_unf_recon.sv
// Byte reconstruction for the five PNG filter types, including the Paeth predictor.
module png_unf_recon
  import png_unf_pkg::*;
(
  input  logic [7:0] filt_byte,
  input  logic [7:0] row_filter,
  input  nbr_t       nbr,
  output logic [7:0] pixel_byte,
  output logic       bad_filter
);

  logic [9:0] pa;
  logic [9:0] pb;
  logic [9:0] pc;
  logic [9:0] sum_ab;
  logic [9:0] twice_c;
  logic [7:0] paeth_pred;
  logic [8:0] avg_sum;

  // Paeth distances: |b-c|, |a-c|, |a+b-2c|
  always_comb begin
    pa      = (nbr.b > nbr.c) ? 10'(nbr.b - nbr.c) : 10'(nbr.c - nbr.b);
    pb      = (nbr.a > nbr.c) ? 10'(nbr.a - nbr.c) : 10'(nbr.c - nbr.a);
    sum_ab  = 10'(nbr.a) + 10'(nbr.b);
    twice_c = {1'b0, nbr.c, 1'b0};
    pc      = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
    if ((pa <= pb) && (pa <= pc)) begin
      paeth_pred = nbr.a;
    end else if (pb <= pc) begin
      paeth_pred = nbr.b;
    end else begin
      paeth_pred = nbr.c;
    end
    avg_sum = 9'(nbr.a) + 9'(nbr.b);
  end

  // Add the prediction back, modulo 256; pass unknown types through flagged
  always_comb begin
    bad_filter = 1'b0;
    case (row_filter)
      FILT_NONE:  pixel_byte = filt_byte;
      FILT_SUB:   pixel_byte = filt_byte + nbr.a;
      FILT_UP:    pixel_byte = filt_byte + nbr.b;
      FILT_AVG:   pixel_byte = filt_byte + avg_sum[8:1];
      FILT_PAETH: pixel_byte = filt_byte + paeth_pred;
      default: begin
        pixel_byte = filt_byte;
        bad_filter = 1'b1;
      end
    endcase
  end

endmodule

FILE: bench/png_scanline_unfilter_tb.sv
// Self-checking testbench for the PNG scanline unfilter with a byte-level row predictor.
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
  import png_unf_pkg::*;

  localparam int ROW_STORE_DEPTH = 32768;

  // Filter types beyond the defined set
  localparam logic [7:0] FILT_FIRST_BAD = 8'd5;
  localparam logic [7:0] FILT_TOP_BAD   = 8'hFF;

  // Colour types that carry a single channel
  localparam logic [COLOR_W-1:0] COLOR_GRAY       = 3'd0;
  localparam logic [COLOR_W-1:0] COLOR_PALETTE    = 3'd3;
  localparam logic [COLOR_W-1:0] COLOR_RESERVED_5 = 3'd5;
  localparam logic [COLOR_W-1:0] COLOR_RESERVED_7 = 3'd7;

  // Register indexes past the defined set
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPARE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_SPARE  = 3'd7;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [DEPTH_W-1:0]  depth;
    logic [COLOR_W-1:0]  color;
    logic [STRIDE_W-1:0] stride;
  } geometry_t;

  localparam int SHAPE_COUNT = 12;
  localparam geometry_t SHAPES [SHAPE_COUNT] = '{
    '{13'd1,  5'd8,  COLOR_GRAY,       4'd1},
    '{13'd5,  5'd8,  COLOR_RGB,        4'd3},
    '{13'd4,  5'd16, COLOR_RGBA,       4'd8},
    '{13'd7,  5'd1,  COLOR_GRAY,       4'd1},
    '{13'd13, 5'd2,  COLOR_GRAY_ALPHA, 4'd1},
    '{13'd9,  5'd4,  COLOR_PALETTE,    4'd1},
    '{13'd0,  5'd8,  COLOR_GRAY,       4'd0},
    '{13'd3,  5'd0,  COLOR_RGBA,       4'd15},
    '{13'd6,  5'd8,  COLOR_RGBA,       4'd9},
    '{13'd2,  5'd16, COLOR_RGB,        4'd6},
    '{13'd10, 5'd31, COLOR_RESERVED_5, 4'd2},
    '{13'd3,  5'd8,  COLOR_RESERVED_7, 4'd4}
  };

  // Opening beats on a two-byte row: every filter, wrap-round sums, bad types,
  // a restart part way through a row
  localparam int OPENING_COUNT = 26;
  localparam in_beat_t OPENING [OPENING_COUNT] = '{
    '{FILT_NONE, 1'b1},  '{8'hFF, 1'b0}, '{8'h00, 1'b0},
    '{FILT_SUB, 1'b0},   '{8'h80, 1'b0}, '{8'h80, 1'b0},
    '{FILT_UP, 1'b0},    '{8'hFF, 1'b0}, '{8'h01, 1'b0},
    '{FILT_AVG, 1'b0},   '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
    '{FILT_PAETH, 1'b0}, '{8'h10, 1'b0}, '{8'hF0, 1'b0},
    '{FILT_FIRST_BAD, 1'b0}, '{8'h5A, 1'b0}, '{8'hA5, 1'b0},
    '{FILT_TOP_BAD, 1'b0},   '{8'hC3, 1'b0}, '{8'h3C, 1'b0},
    '{FILT_UP, 1'b0},    '{8'h33, 1'b0},
    '{FILT_PAETH, 1'b1}, '{8'h7E, 1'b0}, '{8'h81, 1'b0}
  };

  // Row predictor and queue of pixel beats still owed by the block
  class row_rebuilder;
    int img_width, depth, color, stride;
    logic [7:0] above_row [ROW_STORE_DEPTH];
    logic [7:0] left_hist [HIST_DEPTH];
    logic [7:0] upleft_hist [HIST_DEPTH];
    int col_idx;
    bit want_type;
    bit first_row;
    logic [7:0] filt;
    int hi_water;
    int mismatches;
    out_beat_t pixels_due [$];

    function new();
      img_width = 1;
      depth = 8;
      color = 0;
      stride = 1;
      col_idx = 0;
      want_type = 1'b1;
      first_row = 1'b1;
      filt = FILT_NONE;
      hi_water = 0;
      mismatches = 0;
      foreach (left_hist[i]) begin
        left_hist[i] = 8'h00;
        upleft_hist[i] = 8'h00;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  img_width = int'(value[WIDTH_W-1:0]);
        REG_SAMPLE_DEPTH: depth = int'(value[DEPTH_W-1:0]);
        REG_COLOR_KIND:   color = int'(value[COLOR_W-1:0]);
        REG_PIXEL_STRIDE: stride = int'(value[STRIDE_W-1:0]);
        default: ;
      endcase
    endfunction

    function int row_bytes();
      int chans, bits, n;
      case (color)
        COLOR_RGB:        chans = 3;
        COLOR_GRAY_ALPHA: chans = 2;
        COLOR_RGBA:       chans = 4;
        default:          chans = 1;
      endcase
      bits = img_width * chans * depth;
      n = (bits + 7) / 8;
      if (n == 0) n = 1;
      if (n > ROW_STORE_DEPTH) n = ROW_STORE_DEPTH;
      return n;
    endfunction

    function int paeth_pick(int a, int b, int c);
      int pa, pb, pc;
      pa = (b > c) ? b - c : c - b;
      pb = (a > c) ? a - c : c - a;
      pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    // The next beat would fetch an above byte that no row has yet written
    function bit would_read_unwritten();
      return !want_type && !first_row && col_idx >= hi_water;
    endfunction

    function void accept_byte(in_beat_t beat);
      int len, s, col, a, b, c, r;
      out_beat_t want;
      if (beat.start_of_image) begin
        first_row = 1'b1;
        want_type = 1'b1;
        col_idx = 0;
      end
      if (want_type) begin
        filt = beat.data_byte;
        want_type = 1'b0;
        col_idx = 0;
        return;
      end
      len = row_bytes();
      s = stride;
      if (s == 0) s = 1;
      if (s > MAX_STRIDE) s = MAX_STRIDE;
      col = col_idx;
      if (col >= ROW_STORE_DEPTH) col = ROW_STORE_DEPTH - 1;

      // Gather the neighbours: zeros above on the first row, zeros left at the edge
      b = first_row ? 0 : above_row[col];
      a = 0;
      c = 0;
      if (col >= s) begin
        a = left_hist[(col - s) % HIST_DEPTH];
        c = upleft_hist[(col - s) % HIST_DEPTH];
      end

      want.bad_filter = 1'b0;
      case (filt)
        FILT_NONE:  r = beat.data_byte;
        FILT_SUB:   r = beat.data_byte + a;
        FILT_UP:    r = beat.data_byte + b;
        FILT_AVG:   r = beat.data_byte + ((a + b) >> 1);
        FILT_PAETH: r = beat.data_byte + paeth_pick(a, b, c);
        default: begin
          r = beat.data_byte;
          want.bad_filter = 1'b1;
        end
      endcase
      want.pixel_byte = r[7:0];

      upleft_hist[col % HIST_DEPTH] = b[7:0];
      left_hist[col % HIST_DEPTH] = r[7:0];
      above_row[col] = r[7:0];
      if (col + 1 > hi_water) hi_water = col + 1;

      want.last_of_row = (col + 1 >= len);
      if (want.last_of_row) begin
        col_idx = 0;
        want_type = 1'b1;
        first_row = 1'b0;
      end else begin
        col_idx = col + 1;
      end
      pixels_due.push_back(want);
    endfunction

    function void check_pixel(out_beat_t got);
      out_beat_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t: pixel beat with none owed, expected nothing, got %h", $time, got);
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_byte !== want.pixel_byte) begin
        mismatches++;
        $display("%0t: pixel_byte expected %h got %h", $time, want.pixel_byte, got.pixel_byte);
      end
      if (got.last_of_row !== want.last_of_row) begin
        mismatches++;
        $display("%0t: last_of_row expected %b got %b", $time, want.last_of_row,
                 got.last_of_row);
      end
      if (got.bad_filter !== want.bad_filter) begin
        mismatches++;
        $display("%0t: bad_filter expected %b got %b", $time, want.bad_filter, got.bad_filter);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_beat_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  row_rebuilder rebuilder = new();
  bit calm = 1'b0;
  bit fresh_image = 1'b1;
  int rows_left = 0;

  png_scanline_unfilter #(
    .MAX_ROW_BYTES(ROW_STORE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one beat and hold it until the block takes it
  task automatic send_beat(input in_beat_t beat);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    rebuilder.accept_byte(beat);
  endtask

  // Write all four registers plus one spare index, then drop the enable
  task automatic set_geometry(input geometry_t shape);
    logic [CFG_INDEX_W-1:0] idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_IMAGE_WIDTH, REG_SAMPLE_DEPTH, REG_COLOR_KIND, REG_PIXEL_STRIDE,
            CFG_INDEX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE))};
    val = '{CFG_DATA_W'(shape.width), CFG_DATA_W'(shape.depth), CFG_DATA_W'(shape.color),
            CFG_DATA_W'(shape.stride), CFG_DATA_W'($urandom_range(0, 8191))};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      rebuilder.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Hold off until every owed pixel has come back, then let the pipe settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    while (rebuilder.pixels_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Mostly whole images of a few rows with random bytes; some restarts and bad types
  task automatic feed_stream(input int count, input bit noisy);
    in_beat_t beat;
    bit open_image;
    for (int n = 0; n < count; n++) begin
      beat.data_byte = 8'($urandom_range(0, 255));
      open_image = fresh_image || rebuilder.would_read_unwritten() ||
                   (noisy && $urandom_range(0, 99) < 2) ||
                   (rebuilder.want_type && rows_left == 0);
      beat.start_of_image = open_image;
      if (open_image) begin
        fresh_image = 1'b0;
        rows_left = $urandom_range(1, 6);
      end
      if (open_image || rebuilder.want_type) begin
        beat.data_byte = ($urandom_range(0, 9) == 0) ?
                         8'($urandom_range(FILT_FIRST_BAD, FILT_TOP_BAD)) :
                         8'($urandom_range(FILT_NONE, FILT_PAETH));
        if (rows_left > 0) rows_left--;
      end
      send_beat(beat);
      if (!calm && $urandom_range(0, 99) < 5) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Result side: check each beat taken, stall now and then
  initial begin
    forever begin
      @(negedge clk);
      if (out_valid && out_ready) rebuilder.check_pixel(out_data);
      @(posedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    geometry_t shape;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening on a two-byte row
    set_geometry('{13'd2, 5'd8, COLOR_GRAY, 4'd1});
    for (int i = 0; i < OPENING_COUNT; i++) send_beat(OPENING[i]);
    in_valid <= 1'b0;
    wait_drained();

    // Fixed shapes, then random small ones; phases end wherever they stop
    for (int p = 0; p < SHAPE_COUNT; p++) begin
      set_geometry(SHAPES[p]);
      calm = (p == 4);
      feed_stream(calm ? 150 : 50, 1'b1);
      calm = 1'b0;
      wait_drained();
    end
    for (int p = 0; p < 6; p++) begin
      shape.width = WIDTH_W'($urandom_range(1, 12));
      shape.depth = DEPTH_W'(1 << $urandom_range(0, 4));
      shape.color = COLOR_W'($urandom_range(0, 7));
      shape.stride = STRIDE_W'($urandom_range(0, 15));
      set_geometry(shape);
      feed_stream(50, 1'b1);
      wait_drained();
    end

    // Widest row: saturated length, the opening bytes of a fresh image
    set_geometry('{13'd8191, 5'd31, COLOR_RGBA, 4'd15});
    fresh_image = 1'b1;
    feed_stream(42, 1'b0);
    wait_drained();

    // Shrink mid-row: the column is already past the new length
    set_geometry('{13'd3, 5'd8, COLOR_RGB, 4'd2});
    feed_stream(60, 1'b1);
    wait_drained();

    if (rebuilder.pixels_due.size() != 0) begin
      rebuilder.mismatches++;
      $display("%0t: %0d pixel beats expected but never seen", $time,
               rebuilder.pixels_due.size());
    end
    if (rebuilder.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
